[design/dsc_pkg.sv]
// dsc_pkg: shared types, constants and the status word decoder for the
// drive state controller. No dependencies.
`default_nettype none

package dsc_pkg;

    // Drive states, as reported on the result item
    typedef enum logic [3:0] {
        ST_START       = 4'd0,
        ST_NOT_READY   = 4'd1,
        ST_DISABLED    = 4'd2,
        ST_READY       = 4'd3,
        ST_SWITCHED_ON = 4'd4,
        ST_ENABLED     = 4'd5,
        ST_QUICKSTOP   = 4'd6,
        ST_FAULT_REACT = 4'd7,
        ST_FAULT       = 4'd8,
        ST_UNDEFINED   = 4'd9
    } t_drive_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_AUTO_TRANSITIONS     = 2'd0;
    localparam logic [1:0] CFG_AUTO_CLEAR_FAULT     = 2'd1;
    localparam logic [1:0] CFG_RESET_REQUEST_ENABLE = 2'd2;

    // Status word masks and patterns
    localparam logic [15:0] SW_MASK_A        = 16'h004F;
    localparam logic [15:0] SW_MASK_B        = 16'h006F;
    localparam logic [15:0] SW_NOT_READY     = 16'h0000;
    localparam logic [15:0] SW_DISABLED      = 16'h0040;
    localparam logic [15:0] SW_READY         = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON   = 16'h0023;
    localparam logic [15:0] SW_ENABLED       = 16'h0027;
    localparam logic [15:0] SW_QUICKSTOP     = 16'h0007;
    localparam logic [15:0] SW_FAULT_REACT   = 16'h000F;
    localparam logic [15:0] SW_FAULT         = 16'h0008;

    // Control word masks and forced bits for the automatic transitions
    localparam logic [15:0] CW_MASK_SHUTDOWN  = 16'h007E;
    localparam logic [15:0] CW_SET_SHUTDOWN   = 16'h0006;
    localparam logic [15:0] CW_MASK_SWITCH_ON = 16'h0077;
    localparam logic [15:0] CW_SET_SWITCH_ON  = 16'h0007;
    localparam logic [15:0] CW_MASK_ENABLE    = 16'h007F;
    localparam logic [15:0] CW_SET_ENABLE     = 16'h000F;
    localparam logic [15:0] CW_MASK_FAULT_RST = 16'h00FF;
    localparam logic [15:0] CW_SET_FAULT_RST  = 16'h0080;

    typedef struct packed {
        logic [15:0] drv_status;
        logic [15:0] host_cw;
        logic        operational;
        logic        reset_request;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cmd_cw;
        logic [3:0]  drive_state;
        logic        initialized;
    } t_out_item;

    typedef struct packed {
        logic auto_transitions;
        logic auto_clear_fault;
        logic reset_request_enable;
    } t_cfg;

    typedef struct packed {
        t_drive_state cur_state;
        logic [15:0]  prev_status;
        logic         reset_pending;
        logic         request_seen;
    } t_ctl_state;

    // Status word to drive state, first matching pattern wins
    function automatic t_drive_state decode_status(input logic [15:0] sw);
        logic [15:0] a;
        logic [15:0] b;
        a = sw & SW_MASK_A;
        b = sw & SW_MASK_B;
        if (a == SW_NOT_READY)          decode_status = ST_NOT_READY;
        else if (a == SW_DISABLED)      decode_status = ST_DISABLED;
        else if (b == SW_READY)         decode_status = ST_READY;
        else if (b == SW_SWITCHED_ON)   decode_status = ST_SWITCHED_ON;
        else if (b == SW_ENABLED)       decode_status = ST_ENABLED;
        else if (b == SW_QUICKSTOP)     decode_status = ST_QUICKSTOP;
        else if (a == SW_FAULT_REACT)   decode_status = ST_FAULT_REACT;
        else if (a == SW_FAULT)         decode_status = ST_FAULT;
        else                            decode_status = ST_UNDEFINED;
    endfunction

endpackage

`default_nettype wire

[design/dsc_step.sv]
// dsc_step: per-item logic of the drive state controller: request edge
// detection, control word rewrite and status decode. Uses dsc_pkg.
`default_nettype none

module dsc_step (
    input  dsc_pkg::t_cfg       i_cfg,
    input  dsc_pkg::t_ctl_state i_state,
    input  dsc_pkg::t_in_item   i_item,
    output dsc_pkg::t_ctl_state o_state,
    output dsc_pkg::t_out_item  o_item
);
    import dsc_pkg::*;

    logic         seen_n;
    logic         pend_edge;
    logic         pend_clr;
    logic [15:0]  cw;
    logic [15:0]  cw_out;
    t_drive_state state_n;

    assign cw = i_item.host_cw;

    // Host fault reset request: rising edge sets a pending request
    always_comb begin
        seen_n    = i_state.request_seen;
        pend_edge = i_state.reset_pending;
        if (i_item.operational && i_cfg.reset_request_enable) begin
            seen_n    = i_item.reset_request;
            pend_edge = i_state.reset_pending
                        | (i_item.reset_request & ~i_state.request_seen);
        end
    end

    // Control word rewrite from the state held before this item
    always_comb begin
        cw_out   = cw;
        pend_clr = 1'b0;
        if (i_item.operational && i_cfg.auto_transitions) begin
            case (i_state.cur_state)
                ST_DISABLED: cw_out = (cw & CW_MASK_SHUTDOWN) | CW_SET_SHUTDOWN;
                ST_READY:    cw_out = (cw & CW_MASK_SWITCH_ON) | CW_SET_SWITCH_ON;
                ST_SWITCHED_ON, ST_QUICKSTOP:
                             cw_out = (cw & CW_MASK_ENABLE) | CW_SET_ENABLE;
                ST_FAULT: begin
                    if (i_cfg.auto_clear_fault || pend_edge) begin
                        cw_out   = (cw & CW_MASK_FAULT_RST) | CW_SET_FAULT_RST;
                        pend_clr = 1'b1;
                    end
                end
                default:     cw_out = cw;
            endcase
        end
    end

    // Re-decode only when the status word changed
    assign state_n = (i_item.drv_status != i_state.prev_status)
                     ? decode_status(i_item.drv_status) : i_state.cur_state;

    always_comb begin
        o_state.cur_state     = state_n;
        o_state.prev_status   = i_item.drv_status;
        o_state.reset_pending = pend_edge & ~pend_clr;
        o_state.request_seen  = seen_n;
    end

    // Held state before this item is the previous item's state
    always_comb begin
        o_item.cmd_cw      = cw_out;
        o_item.drive_state = state_n;
        o_item.initialized = (state_n == ST_ENABLED)
                             && (i_state.cur_state == ST_ENABLED);
    end

endmodule

`default_nettype wire

[design/drive_state_controller_top.sv]
// drive_state_controller_top: input register, controller state, result
// register and configuration registers. Uses dsc_pkg and dsc_step.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_in_item         | item in
//   out     | o_out_valid, i_out_ready, o_out_item      | item out
//   cfg     | i_cfg_we, i_cfg_addr, i_cfg_data          | write only
//
// One item per clock while the output is not stalled; the path runs from the
// input register to the result register through one pass of the step logic.
// Controller state updates in the same edge that loads the result register,
// so the next item always sees the state this one left.
// A stalled output holds the result register; the input register then holds
// too and o_in_ready drops once it is full.
// Synchronous active-low reset clears all valid, state and config registers.
`default_nettype none

module drive_state_controller_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  dsc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output dsc_pkg::t_out_item o_out_item,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_addr,
    input  wire                i_cfg_data
);
    import dsc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_cfg       r_cfg;
    t_ctl_state r_state;
    t_ctl_state n_state;
    t_out_item  n_out;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_AUTO_TRANSITIONS:     r_cfg.auto_transitions     <= i_cfg_data;
                CFG_AUTO_CLEAR_FAULT:     r_cfg.auto_clear_fault     <= i_cfg_data;
                CFG_RESET_REQUEST_ENABLE: r_cfg.reset_request_enable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    dsc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_item  (n_out)
    );

    // Controller state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{cur_state: ST_START, prev_status: '0,
                             reset_pending: 1'b0, request_seen: 1'b0};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A pending result always matches the held controller state
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.drive_state == r_state.cur_state))
        else $error("result drive_state differs from held state");

    // Initialized only in operation enabled
    a_init_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.initialized) |-> (r_out.drive_state == ST_ENABLED))
        else $error("initialized outside operation enabled");

    // Non-operational items pass the control word through
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in.operational) |=>
            (r_out.cmd_cw == $past(r_in.host_cw)))
        else $error("control word rewritten while not operational");

    // A held input item is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost a waiting item");

endmodule

`default_nettype wire

[bench/drive_state_checker.sv]
`timescale 1ns / 100ps
// drive_state_checker: watches the item, result and register ports of the
// drive state controller, predicts every result and compares it field by field.
// Depends on dsc_pkg only.

module drive_state_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  dsc_pkg::t_in_item  i_in_item,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  dsc_pkg::t_out_item i_out_item,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_addr,
    input  wire                i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import dsc_pkg::*;

    // Register copies
    logic cfg_auto_step;
    logic cfg_auto_clear;
    logic cfg_request_enable;

    // Controller state as the predictor sees it
    t_drive_state drive_st;
    t_drive_state drive_st_last;
    logic [15:0]  status_last;
    logic         fault_reset_pending;
    logic         request_high;

    t_out_item expected_results[$];
    int        mismatches = 0;

    // Status word to drive state; bit 4 and bits 15..7 never matter
    function automatic t_drive_state state_of_status(input logic [15:0] sw);
        casez (sw[6:0])
            7'b0??0000: return ST_NOT_READY;
            7'b1??0000: return ST_DISABLED;
            7'b01?0001: return ST_READY;
            7'b01?0011: return ST_SWITCHED_ON;
            7'b01?0111: return ST_ENABLED;
            7'b00?0111: return ST_QUICKSTOP;
            7'b0??1111: return ST_FAULT_REACT;
            7'b0??1000: return ST_FAULT;
            default:    return ST_UNDEFINED;
        endcase
    endfunction

    // Advances the predicted controller by one item and returns its result
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item   res;
        logic [15:0] cw;
        cw = it.host_cw;
        if (it.operational) begin
            // rising edge of the host reset request arms a pending fault reset
            if (cfg_request_enable) begin
                if (!it.reset_request) begin
                    request_high = 1'b0;
                end else if (!request_high) begin
                    request_high        = 1'b1;
                    fault_reset_pending = 1'b1;
                end
            end
            // control word rewrite uses the state held before this item
            if (cfg_auto_step) begin
                case (drive_st)
                    ST_DISABLED: begin
                        cw = (cw & 16'h007E) | 16'h0006;   // shutdown
                    end
                    ST_READY: begin
                        cw = (cw & 16'h0077) | 16'h0007;   // switch on
                    end
                    ST_SWITCHED_ON, ST_QUICKSTOP: begin
                        cw = (cw & 16'h007F) | 16'h000F;   // enable operation
                    end
                    ST_FAULT: begin
                        if (cfg_auto_clear || fault_reset_pending) begin
                            fault_reset_pending = 1'b0;
                            cw = (cw & 16'h00FF) | 16'h0080;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (it.drv_status != status_last)
            drive_st = state_of_status(it.drv_status);
        res.cmd_cw      = cw;
        res.drive_state = drive_st;
        res.initialized = (drive_st == ST_ENABLED) && (drive_st_last == ST_ENABLED);
        status_last   = it.drv_status;
        drive_st_last = drive_st;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    // Sample both channels and the register port on every rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_auto_step        = 1'b0;
            cfg_auto_clear       = 1'b0;
            cfg_request_enable   = 1'b0;
            drive_st             = ST_START;
            drive_st_last        = ST_START;
            status_last          = 16'h0000;
            fault_reset_pending  = 1'b0;
            request_high         = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_AUTO_TRANSITIONS:     cfg_auto_step      = i_cfg_data;
                    CFG_AUTO_CLEAR_FAULT:     cfg_auto_clear     = i_cfg_data;
                    CFG_RESET_REQUEST_ENABLE: cfg_request_enable = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %h arrived with nothing predicted",
                                 $time, i_out_item);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.cmd_cw !== want.cmd_cw)
                        note_mismatch("cmd_cw", want.cmd_cw, i_out_item.cmd_cw);
                    if (i_out_item.drive_state !== want.drive_state)
                        note_mismatch("drive_state", 16'(want.drive_state),
                                      16'(i_out_item.drive_state));
                    if (i_out_item.initialized !== want.initialized)
                        note_mismatch("initialized", 16'(want.initialized),
                                      16'(i_out_item.initialized));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_result(i_in_item));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

[bench/drive_state_controller_top_tb.sv]
`timescale 1ns / 100ps
// drive_state_controller_top_tb: clock, reset, register writes and item traffic
// for the drive state controller; verdict from drive_state_checker.
// Depends on dsc_pkg, drive_state_controller_top and drive_state_checker.

module drive_state_controller_top_tb;
    import dsc_pkg::*;

    localparam int RANDOM_ITEMS_PER_SETTING = 136;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic        cfg_data;
    int          pending;
    int          fail_count;

    // Traffic shaping and drive walk
    bit           sender_burst   = 1'b0;
    bit           receiver_burst = 1'b0;
    bit           request_level  = 1'b0;
    t_drive_state walk_state     = ST_NOT_READY;
    logic [15:0]  last_status    = 16'h0000;
    int           items_sent     = 0;
    int           settings_used  = 0;

    always #5 clk = ~clk;

    drive_state_controller_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    drive_state_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Next state of a drive that mostly heads for operation enabled
    function automatic t_drive_state advance_walk(input t_drive_state s);
        if ($urandom_range(0, 1) == 0)
            return s;
        case (s)
            ST_NOT_READY:   return ST_DISABLED;
            ST_DISABLED:    return ST_READY;
            ST_READY:       return ST_SWITCHED_ON;
            ST_SWITCHED_ON: return ST_ENABLED;
            ST_ENABLED: begin
                case ($urandom_range(0, 9))
                    0:       return ST_QUICKSTOP;
                    1:       return ST_FAULT_REACT;
                    2:       return ST_DISABLED;
                    default: return ST_ENABLED;
                endcase
            end
            ST_QUICKSTOP:   return ST_DISABLED;
            ST_FAULT_REACT: return ST_FAULT;
            ST_FAULT: begin
                if ($urandom_range(0, 3) == 0)
                    return ST_DISABLED;
                return ST_FAULT;
            end
            default:        return ST_NOT_READY;
        endcase
    endfunction

    // Status word for a drive state, random in every bit the decode ignores
    function automatic logic [15:0] status_for(input t_drive_state s);
        logic [15:0] noise;
        noise = 16'($urandom);
        case (s)
            ST_NOT_READY:   return (noise & ~SW_MASK_A) | SW_NOT_READY;
            ST_DISABLED:    return (noise & ~SW_MASK_A) | SW_DISABLED;
            ST_READY:       return (noise & ~SW_MASK_B) | SW_READY;
            ST_SWITCHED_ON: return (noise & ~SW_MASK_B) | SW_SWITCHED_ON;
            ST_ENABLED:     return (noise & ~SW_MASK_B) | SW_ENABLED;
            ST_QUICKSTOP:   return (noise & ~SW_MASK_B) | SW_QUICKSTOP;
            ST_FAULT_REACT: return (noise & ~SW_MASK_A) | SW_FAULT_REACT;
            ST_FAULT:       return (noise & ~SW_MASK_A) | SW_FAULT;
            default:        return noise;
        endcase
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input t_in_item it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        last_status = it.drv_status;
        items_sent++;
    endtask

    task automatic send_fields(input logic [15:0] sw, input logic [15:0] cw,
                               input logic op, input logic req);
        t_in_item it;
        it.drv_status    = sw;
        it.host_cw       = cw;
        it.operational   = op;
        it.reset_request = req;
        send_item(it);
    endtask

    // Mostly a walking drive, some repeated and some arbitrary status words
    task automatic send_random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.drv_status = 16'($urandom);
        end else if (pick < 27) begin
            it.drv_status = last_status;
        end else begin
            walk_state    = advance_walk(walk_state);
            it.drv_status = status_for(walk_state);
        end
        it.host_cw     = 16'($urandom);
        it.operational = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 2) == 0)
            request_level = !request_level;
        it.reset_request = request_level;
        send_item(it);
    endtask

    // Let the block drain, then write all three registers
    task automatic settle_and_configure(input bit auto_step, input bit auto_clear,
                                        input bit request_enable);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_AUTO_TRANSITIONS;
        cfg_data <= auto_step;
        @(posedge clk);
        cfg_addr <= CFG_AUTO_CLEAR_FAULT;
        cfg_data <= auto_clear;
        @(posedge clk);
        cfg_addr <= CFG_RESET_REQUEST_ENABLE;
        cfg_data <= request_enable;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stall before each item, with stall-free stretches
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_addr = CFG_AUTO_TRANSITIONS;
        cfg_data = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Power-on registers: zero status keeps the start state
        send_fields(16'h0000, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h0000, 16'h0000, 1'b0, 1'b1);

        // Rewrites with host reset requests honored
        settle_and_configure(1'b1, 1'b0, 1'b1);
        send_fields(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);   // undefined, arms a reset
        send_fields(16'h0040, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h0040, 16'hFFFF, 1'b1, 1'b0);   // unchanged status word
        send_fields(16'h0021, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h0023, 16'h0000, 1'b1, 1'b0);
        send_fields(16'h0027, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h8027, 16'hFFFF, 1'b1, 1'b0);   // enabled twice running
        send_fields(16'h0007, 16'h0000, 1'b1, 1'b0);
        send_fields(16'h000F, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h0008, 16'hFFFF, 1'b1, 1'b0);
        send_fields(16'h0018, 16'hFFFF, 1'b1, 1'b0);   // old request used in fault
        send_fields(16'h0008, 16'hFFFF, 1'b1, 1'b1);   // new edge in fault
        send_fields(16'h0018, 16'hFFFF, 1'b1, 1'b1);   // held request, no edge
        send_fields(16'h0008, 16'hABCD, 1'b0, 1'b0);   // link down, passthrough
        send_fields(16'h0000, 16'hFFFF, 1'b1, 1'b1);

        // Automatic fault reset, host request ignored
        settle_and_configure(1'b1, 1'b1, 1'b0);
        send_fields(16'h0008, 16'h1234, 1'b1, 1'b0);
        send_fields(16'h0028, 16'hFFFF, 1'b1, 1'b1);
        send_fields(16'hFFFF, 16'h0000, 1'b0, 1'b1);
        send_fields(16'h0000, 16'hFFFF, 1'b1, 1'b0);

        // Random traffic under every register setting
        for (int setting = 0; setting < 8; setting++) begin
            settle_and_configure(setting[0], setting[1], setting[2]);
            repeat (RANDOM_ITEMS_PER_SETTING) send_random_item();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d items under %0d register settings, gaps of 0 to 11 cycles",
                 items_sent, settings_used);
        $display("on both channels; drive walked through every state and fault resets.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

endmodule
